// ----- design/dpt_pkg.sv -----
// Types, constants and register codes shared by the duplicate packet table.
package dpt_pkg;

  // Field widths of one transaction
  localparam int unsigned IdW   = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned SeqW  = 31;
  localparam int unsigned TimeW = 64;

  // Table size default
  localparam int unsigned TableDepthDef = 16;

  // Register reset values
  localparam logic [TimeW-1:0] ExpiryReset = 64'd10000000000;
  localparam logic [KindW-1:0] ReplyReset  = 2'd1;

  // Register map: 64-bit registers at 8-byte spacing
  localparam int unsigned AddrW    = 4;
  localparam int unsigned CfgDataW = 64;
  localparam logic RegExpiry = 1'b0;
  localparam logic RegReply  = 1'b1;

  // Command codes
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  // Stream payload widths
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 8;

  // One stored packet record
  typedef struct packed {
    logic [TimeW-1:0] time_ns;
    logic [SeqW-1:0]  seq;
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   dest;
    logic [IdW-1:0]   origin;
  } entry_t;

endpackage

// ----- design/duplicate_packet_table.sv -----
// Duplicate packet table: keyed record of recent packets with ageing on update.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: origin,dest,kind,seq,now; tuser: cmd
// m_axis    out  m_axis_tvalid/tready        tdata: seen,refreshed,dropped_full
// apb       in   psel&penable&pwrite&pready  0x0 expiry_time, 0x8 reply_type_code
//
// A transaction scans the whole table: the table memory has one read port, so
// the shared compare unit sees one entry a cycle, then the write-back state
// writes back and loads the result register.
// Reset clears the valid bits and the control state; the records need none.
// The input is stalled while a transaction is in flight; a held result stalls
// only the final write-back cycle of the next transaction.
module duplicate_packet_table #(
  parameter int unsigned TABLE_DEPTH = dpt_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] origin_id, [31:16] dest_id, [33:32] kind, [64:34] seq_num,
  // [128:65] now, [135:129] zero
  input  logic [dpt_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] cmd
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] seen, [1] refreshed, [2] dropped_full, [7:3] zero
  output logic [dpt_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpt_pkg::AddrW-1:0]     paddr,
  input  logic [dpt_pkg::CfgDataW-1:0]  pwdata,
  output logic [dpt_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import dpt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                 state_q;
  logic [TimeW-1:0]       expiry_q;
  logic [KindW-1:0]       reply_q;
  logic                   cmd_q;
  entry_t                 item_q;
  logic [CW-1:0]          rd_ptr_q;
  logic                   cmp_v_q;
  logic [IW-1:0]          cmp_idx_q;
  logic                   hit_q;
  logic [IW-1:0]          hit_idx_q;
  logic                   free_q;
  logic [IW-1:0]          free_idx_q;
  logic                   seen_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   m_valid_q;
  logic [2:0]             m_flags_q;

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_q;

  logic                   in_acc;
  logic                   cfg_wr;
  logic                   rd_en;
  logic                   out_free;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic                   ent_valid;
  logic                   key_hit;
  logic                   exact;
  logic                   first_hit;
  logic [TimeW-1:0]       age;
  logic                   expired;
  logic                   seq_ok;
  logic                   last_cmp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3])
      RegExpiry: prdata = expiry_q;
      RegReply:  prdata = {{(CfgDataW-KindW){1'b0}}, reply_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ExpiryReset;
      reply_q  <= ReplyReset;
    end else if (cfg_wr) begin
      case (paddr[3])
        RegExpiry: expiry_q <= pwdata;
        RegReply:  reply_q  <= pwdata[KindW-1:0];
        default:   ;
      endcase
    end
  end

  // Shared compare unit: one stored entry a cycle
  assign ent_valid = valid_q[cmp_idx_q];
  assign key_hit   = ent_valid && (rd_q.origin == item_q.origin) &&
                     (rd_q.dest == item_q.dest) && (rd_q.kind == item_q.kind);
  assign exact     = key_hit && (rd_q.seq == item_q.seq);
  assign first_hit = exact && !hit_q;
  assign age       = item_q.time_ns - rd_q.time_ns;
  assign expired   = ent_valid && (age > expiry_q);
  assign seq_ok    = (item_q.kind == reply_q) ? (rd_q.seq > item_q.seq)
                                              : (rd_q.seq >= item_q.seq);
  assign last_cmp  = cmp_v_q && (cmp_idx_q == IW'(TABLE_DEPTH - 1));

  // Read issue and write-back control
  assign rd_en     = (state_q == ST_SCAN) && (rd_ptr_q < CW'(TABLE_DEPTH));
  assign mem_we    = (state_q == ST_FIN) && out_free && (cmd_q == CmdUpdate) &&
                     (hit_q || free_q);
  assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;

  // Record memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= item_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_ptr_q[IW-1:0]];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= CmdLookup;
      item_q     <= '0;
      rd_ptr_q   <= '0;
      cmp_v_q    <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      seen_q     <= 1'b0;
      valid_q    <= '0;
      m_valid_q  <= 1'b0;
      m_flags_q  <= '0;
    end else begin
      // write-back reloads the result itself when the old one leaves
      if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q          <= s_axis_tuser;
            item_q.origin  <= s_axis_tdata[15:0];
            item_q.dest    <= s_axis_tdata[31:16];
            item_q.kind    <= s_axis_tdata[33:32];
            item_q.seq     <= s_axis_tdata[64:34];
            item_q.time_ns <= s_axis_tdata[128:65];
            rd_ptr_q       <= '0;
            cmp_v_q        <= 1'b0;
            hit_q          <= 1'b0;
            free_q         <= 1'b0;
            seen_q         <= 1'b0;
            state_q        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_v_q   <= rd_en;
          cmp_idx_q <= rd_ptr_q[IW-1:0];
          if (rd_en) begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
          end
          if (cmp_v_q) begin
            if (cmd_q == CmdLookup) begin
              if (key_hit && seq_ok) begin
                seen_q <= 1'b1;
              end
            end else begin
              // lowest exact match is kept and refreshed later
              if (first_hit) begin
                hit_q     <= 1'b1;
                hit_idx_q <= cmp_idx_q;
              end
              // age out every expired entry but the kept match
              if (expired && !first_hit) begin
                valid_q[cmp_idx_q] <= 1'b0;
              end
              // lowest slot that is free once ageing is done
              if (!free_q && (!ent_valid || (expired && !first_hit))) begin
                free_q     <= 1'b1;
                free_idx_q <= cmp_idx_q;
              end
            end
          end
          if (last_cmp) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            if (cmd_q == CmdLookup) begin
              m_flags_q <= {1'b0, 1'b0, seen_q};
            end else begin
              m_flags_q <= {!hit_q && !free_q, hit_q, 1'b0};
              if (!hit_q && free_q) begin
                valid_q[free_idx_q] <= 1'b1;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, m_flags_q};

  // A transaction holds off the next one until its write-back is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during a scan");

  // A result is only loaded from the write-back cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside write-back");

  // Refresh and full drop never flagged together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("refreshed and dropped_full both set");

endmodule
